[rtl/cps_pkg.sv]
// Shared types and constants for the chunked prefix sum block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cps_pkg;

    // Fixed field widths of the ports
    localparam int SAMPLE_PORT_W = 32;
    localparam int SUM_W         = 38;
    localparam int POS_W         = 6;
    localparam int LEN_W         = 7;
    localparam int APB_DATA_W    = 32;
    localparam int PADDR_W       = 3;

    // Register indexes (byte address 4*index, decoded from paddr[2])
    localparam logic REG_CHUNK_LENGTH = 1'b0;
    localparam logic REG_REVERSE_MODE = 1'b1;

    // Configuration register contents
    typedef struct packed {
        logic [LEN_W-1:0] chunk_length;
        logic             reverse_mode;
    } t_cfg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_in;   // input transaction accepted this cycle
        logic rd_issue;  // read chunk buffer at the drain index
        logic emit;      // load one suffix sum into the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register empty or being taken
        logic rev_close;  // current sample closes a chunk in reverse mode
        logic k_zero;     // drain index has reached position 0
    } t_dp_status;

endpackage

[rtl/cps_regs.sv]
// APB-style configuration registers: chunk length and reverse mode.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cps_pkg::PADDR_W-1:0]  paddr,
    input  logic [cps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cps_pkg::APB_DATA_W-1:0] prdata,
    output logic                         pready,
    output cps_pkg::t_cfg                o_cfg
);
    import cps_pkg::*;

    logic [LEN_W-1:0] r_chunk_length;
    logic             r_reverse_mode;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_length <= LEN_W'(64);
            r_reverse_mode <= 1'b0;
        end else if (w_wr) begin
            case (paddr[2])
                REG_CHUNK_LENGTH: r_chunk_length <= pwdata[LEN_W-1:0];
                REG_REVERSE_MODE: r_reverse_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        case (paddr[2])
            REG_CHUNK_LENGTH: prdata = APB_DATA_W'(r_chunk_length);
            REG_REVERSE_MODE: prdata = APB_DATA_W'(r_reverse_mode);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.chunk_length = r_chunk_length;
    assign o_cfg.reverse_mode = r_reverse_mode;

endmodule

[rtl/cps_ctrl.sv]
// Controller state machine: accepts samples and sequences the reverse drain.
// Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cps_pkg::t_dp_status i_status,
    output cps_pkg::t_dp_cmd    o_cmd
);
    import cps_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.out_free && i_status.rev_close) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.k_zero ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.take_in  = 1'b0;
        o_cmd.rd_issue = 1'b0;
        o_cmd.emit     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = i_status.out_free;
                o_cmd.take_in = i_in_valid & i_status.out_free;
            end
            ST_READ: o_cmd.rd_issue = 1'b1;
            ST_EMIT: o_cmd.emit = i_status.out_free;
            default: ;
        endcase
    end

    // Checks
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input ready while draining");
    a_read_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_EMIT))
        else $error("buffer read not followed by emit");
    a_close_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_in && i_status.rev_close) |=> (r_state == ST_READ))
        else $error("reverse chunk close did not start drain");

endmodule

[rtl/cps_dp.sv]
// Datapath: position counter, accumulator, chunk buffer, suffix adder and
// output register. Depends on cps_pkg.
`timescale 1ns / 1ps

module cps_dp #(
    parameter int MAX_CHUNK    = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cps_pkg::t_cfg                     i_cfg,
    input  cps_pkg::t_dp_cmd                  i_cmd,
    output cps_pkg::t_dp_status               o_status,
    input  logic [cps_pkg::SAMPLE_PORT_W-1:0] i_sample,
    input  logic                              i_sequence_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [cps_pkg::SUM_W-1:0]  o_running_sum,
    output logic [cps_pkg::POS_W-1:0]         o_chunk_position,
    output logic                              o_run_last
);
    import cps_pkg::*;

    localparam int ADDR_W = $clog2(MAX_CHUNK);

    // Chunk buffer
    logic [SAMPLE_WIDTH-1:0] r_mem [MAX_CHUNK];
    logic [SAMPLE_WIDTH-1:0] r_rd_data;

    logic [POS_W-1:0]        r_pos;
    logic signed [SUM_W-1:0] r_acc;
    logic [ADDR_W-1:0]       r_k;
    logic signed [SUM_W-1:0] r_suffix;
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_out_sum;
    logic [POS_W-1:0]        r_out_pos;
    logic                    r_out_last;

    logic [SAMPLE_WIDTH-1:0] w_samp;
    logic signed [SUM_W-1:0] w_s_ext;
    logic signed [SUM_W-1:0] w_rd_ext;
    logic [POS_W-1:0]        w_pos;
    logic [LEN_W-1:0]        w_n;
    logic [LEN_W-1:0]        w_eff_len;
    logic                    w_closes;
    logic signed [SUM_W-1:0] n_acc;
    logic signed [SUM_W-1:0] n_suffix;
    logic                    w_fwd_load;

    // Sample and buffer word sign extension
    assign w_samp   = i_sample[SAMPLE_WIDTH-1:0];
    assign w_s_ext  = SUM_W'(signed'(w_samp));
    assign w_rd_ext = SUM_W'(signed'(r_rd_data));

    // Write position, clamped to the last buffer entry
    assign w_pos = ({1'b0, r_pos} >= LEN_W'(MAX_CHUNK)) ? POS_W'(MAX_CHUNK - 1) : r_pos;
    assign w_n   = LEN_W'(w_pos) + LEN_W'(1);

    // Effective chunk length: 1..MAX_CHUNK
    always_comb begin
        if (i_cfg.chunk_length == '0) begin
            w_eff_len = LEN_W'(1);
        end else if (i_cfg.chunk_length > LEN_W'(MAX_CHUNK)) begin
            w_eff_len = LEN_W'(MAX_CHUNK);
        end else begin
            w_eff_len = i_cfg.chunk_length;
        end
    end

    assign w_closes   = i_sequence_last | (w_n >= w_eff_len);
    assign n_acc      = (w_pos == '0) ? w_s_ext : r_acc + w_s_ext;
    assign n_suffix   = r_suffix + w_rd_ext;
    assign w_fwd_load = i_cmd.take_in & ~i_cfg.reverse_mode;

    // Status
    assign o_status.out_free  = ~r_out_valid | i_out_ready;
    assign o_status.rev_close = i_cfg.reverse_mode & w_closes;
    assign o_status.k_zero    = (r_k == '0);

    // Buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_mem[w_pos[ADDR_W-1:0]] <= w_samp;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_k];
        end
    end

    // Chunk position and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_acc <= '0;
        end else if (i_cmd.take_in) begin
            if (w_closes) begin
                r_pos <= '0;
                r_acc <= '0;
            end else begin
                r_pos <= w_n[POS_W-1:0];
                r_acc <= n_acc;
            end
        end
    end

    // Drain index and suffix sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_k      <= w_pos[ADDR_W-1:0];
            r_suffix <= '0;
        end else if (i_cmd.emit) begin
            r_k      <= r_k - ADDR_W'(1);
            r_suffix <= n_suffix;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fwd_load || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_fwd_load) begin
            r_out_sum  <= n_acc;
            r_out_pos  <= w_pos;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_sum  <= n_suffix;
            r_out_pos  <= POS_W'(r_k);
            r_out_last <= (r_k == '0);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_running_sum    = r_out_sum;
    assign o_chunk_position = r_out_pos;
    assign o_run_last       = r_out_last;

    // Checks
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pos} < LEN_W'(MAX_CHUNK)))
        else $error("chunk position beyond buffer");
    a_fwd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fwd_load |=> (r_out_valid && r_out_last))
        else $error("forward sample gave no final result");
    a_close_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_in && w_closes) |=> (r_pos == '0))
        else $error("chunk close did not restart position");
    a_last_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_k == '0) |=> r_out_last)
        else $error("suffix drain missed last flag");

endmodule

[rtl/chunked_prefix_sum.sv]
// Chunked prefix sum top level: ties registers, controller and datapath.
// Depends on cps_pkg, cps_regs, cps_ctrl, cps_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one Q16.16 sample and a
//   sequence_last flag per transaction. Output channel (o_out_valid /
//   i_out_ready) carries one running sum, its chunk position and run_last.
//   APB port: chunk_length at 0x0, reverse_mode at 0x4; write only while idle.
//   Forward mode: each sample gives its prefix sum in the output register in the
//   cycle after acceptance; one sample per cycle while the output is taken.
//   Reverse mode: samples are buffered with no result; the sample that closes
//   a chunk of n samples starts a drain of n suffix sums, last position first,
//   each as a buffer read state then an emit state (one buffer read port,
//   registered read, then the add); the next sample is taken only once the
//   drain is done.
//   Receiver stall: the output register holds its result; input is refused
//   while the register is full and not being taken, and the drain pauses.
//   Reset (synchronous, i_rst_n low): chunk_length 64, forward mode, empty
//   chunk, output empty. The chunk buffer needs no clearing.
`timescale 1ns / 1ps

module chunked_prefix_sum #(
    parameter int MAX_CHUNK    = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cps_pkg::PADDR_W-1:0]         paddr,
    input  logic [cps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cps_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [cps_pkg::SAMPLE_PORT_W-1:0] i_sample,
    input  logic                                i_sequence_last,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [cps_pkg::SUM_W-1:0]    o_running_sum,
    output logic [cps_pkg::POS_W-1:0]           o_chunk_position,
    output logic                                o_run_last
);
    import cps_pkg::*;

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Configuration registers
    cps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Controller
    cps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath
    cps_dp #(
        .MAX_CHUNK    (MAX_CHUNK),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_sample         (i_sample),
        .i_sequence_last  (i_sequence_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_running_sum    (o_running_sum),
        .o_chunk_position (o_chunk_position),
        .o_run_last       (o_run_last)
    );

endmodule

[bench/tb_chunked_prefix_sum.sv]
// Self-checking testbench for chunked_prefix_sum: forward prefix and reverse suffix sums.
// Depends on cps_pkg and the chunked_prefix_sum RTL; needs no other files.
`timescale 1ns / 1ps

module tb_chunked_prefix_sum;
    import cps_pkg::*;

    localparam int CHUNK_MAX   = 64;
    // Settling margin once every expected result has been taken
    localparam int DRAIN_SLACK = 4;
    // Bound on the run: samples may wait on receiver stalls or sender gaps of up to 50%,
    // plus two receiver hold-offs; the limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 400000;

    localparam logic MODE_FORWARD = 1'b0;
    localparam logic MODE_REVERSE = 1'b1;

    typedef struct packed {
        logic signed [SUM_W-1:0] running_sum;
        logic [POS_W-1:0]        chunk_pos;
        logic                    run_last;
    } t_sum_entry;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [PADDR_W-1:0]              paddr;
    logic [APB_DATA_W-1:0]           pwdata;
    logic [APB_DATA_W-1:0]           prdata;
    logic                            pready;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic signed [SAMPLE_PORT_W-1:0] i_sample;
    logic                            i_sequence_last;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic signed [SUM_W-1:0]         o_running_sum;
    logic [POS_W-1:0]                o_chunk_position;
    logic                            o_run_last;

    // Mirror of the block's chunk state and configuration
    logic [LEN_W-1:0]                chunk_len_cfg;
    logic                            reverse_cfg;
    logic [POS_W-1:0]                open_count;
    logic signed [SUM_W-1:0]         chunk_acc;
    logic signed [SAMPLE_PORT_W-1:0] chunk_samples [CHUNK_MAX];

    t_sum_entry pending_sums[$];
    t_sum_entry head_sum;

    int mismatches    = 0;
    int cycle_count   = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int hold_left     = 0;

    chunked_prefix_sum u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample        (i_sample),
        .i_sequence_last (i_sequence_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_running_sum   (o_running_sum),
        .o_chunk_position(o_chunk_position),
        .o_run_last      (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Work out the sums one accepted sample causes and queue them
    task automatic predict_sums(input logic signed [SAMPLE_PORT_W-1:0] value,
                                input logic seq_last);
        logic signed [SUM_W-1:0] value_ext;
        logic signed [SUM_W-1:0] suffix;
        int eff_len;
        int count;
        logic closes;
        value_ext = value;
        eff_len = (chunk_len_cfg == 0) ? 1 :
                  (chunk_len_cfg > CHUNK_MAX) ? CHUNK_MAX : int'(chunk_len_cfg);
        chunk_samples[open_count] = value;
        chunk_acc = (open_count == 0) ? value_ext : chunk_acc + value_ext;
        count = int'(open_count) + 1;
        closes = seq_last || (count >= eff_len);
        if (reverse_cfg == MODE_FORWARD) begin
            pending_sums.push_back('{chunk_acc, open_count, 1'b1});
        end else if (closes) begin
            // Drain from the last position down to position 0
            suffix = '0;
            for (int k = count - 1; k >= 0; k--) begin
                suffix = suffix + chunk_samples[k];
                pending_sums.push_back('{suffix, POS_W'(k), k == 0});
            end
        end
        if (closes) begin
            open_count = '0;
            chunk_acc  = '0;
        end else begin
            open_count = POS_W'(count);
        end
    endtask

    // Send one sample transaction, with random sender gaps
    task automatic send_sample(input logic signed [SAMPLE_PORT_W-1:0] value,
                               input logic seq_last);
        if ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_gap_pct);
        end
        i_in_valid      <= 1'b1;
        i_sample        <= value;
        i_sequence_last <= seq_last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_sums(value, seq_last);
    endtask

    // Stop sending and let every queued sum come out
    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reprogram both registers once the block is idle
    task automatic set_config(input int chunk_len, input logic mode);
        wait_drained();
        apb_write({REG_CHUNK_LENGTH, 2'b00}, APB_DATA_W'(chunk_len));
        chunk_len_cfg = LEN_W'(chunk_len);
        apb_write({REG_REVERSE_MODE, 2'b00}, APB_DATA_W'(mode));
        reverse_cfg = mode;
    endtask

    function automatic logic signed [SAMPLE_PORT_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return $urandom_range(255) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic int random_length();
        case ($urandom_range(7))
            0:       return 1;
            1:       return 2;
            2:       return 64;
            3:       return 0;
            4:       return 127;
            5:       return int'($urandom_range(65, 126));
            default: return int'($urandom_range(3, 20));
        endcase
    endfunction

    // Mostly well-formed sequences, with some stray transactions mixed in
    task automatic send_random_sequences(input int item_target);
        int sent;
        int seq_len;
        sent = 0;
        while (sent < item_target) begin
            if ($urandom_range(9) == 0) begin
                send_sample(random_sample(), 1'($urandom_range(1)));
                sent++;
            end else begin
                seq_len = ($urandom_range(7) == 0) ? $urandom_range(25, 80) :
                                                     $urandom_range(1, 24);
                for (int i = 0; i < seq_len; i++) begin
                    send_sample(random_sample(), i == seq_len - 1);
                end
                sent += seq_len;
            end
        end
    endtask

    // Forward mode at reset configuration, then a short chunk length
    task automatic test_forward_directed;
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(-32'sd1, 1'b1);
        set_config(3, MODE_FORWARD);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(32'sh0001_0000, 1'b0);
    endtask

    // Reverse drains: full length, early sequence end, length one and zero
    task automatic test_reverse_directed;
        set_config(4, MODE_REVERSE);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd3, 1'b0);
        send_sample(-32'sd9, 1'b1);
        set_config(1, MODE_REVERSE);
        send_sample(32'sd11, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        // Length zero behaves as one
        set_config(0, MODE_REVERSE);
        send_sample(32'sd12, 1'b0);
        send_sample(-32'sd13, 1'b0);
    endtask

    // Length and mode changes while a chunk is open
    task automatic test_mid_chunk_changes;
        set_config(8, MODE_FORWARD);
        repeat (3) send_sample(random_sample(), 1'b0);
        set_config(2, MODE_FORWARD);
        send_sample(random_sample(), 1'b0);
        set_config(8, MODE_FORWARD);
        repeat (3) send_sample(random_sample(), 1'b0);
        set_config(8, MODE_REVERSE);
        send_sample(random_sample(), 1'b1);
        repeat (2) send_sample(random_sample(), 1'b0);
        set_config(8, MODE_FORWARD);
        send_sample(random_sample(), 1'b0);
    endtask

    // Full 64-sample chunks of extreme values, lengths above the maximum
    task automatic test_full_chunk_extremes;
        set_config(127, MODE_REVERSE);
        repeat (CHUNK_MAX) send_sample(32'sh7FFF_FFFF, 1'b0);
        set_config(100, MODE_FORWARD);
        repeat (CHUNK_MAX) send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sd1, 1'b1);
    endtask

    // Random traffic over several idling phases and configurations
    task automatic test_random_traffic;
        int gap_sched [4]   = '{0, 50, 0, 23};
        int stall_sched [4] = '{0, 0, 50, 23};
        for (int p = 0; p < 4; p++) begin
            in_gap_pct    = gap_sched[p];
            out_stall_pct = stall_sched[p];
            for (int c = 0; c < 2; c++) begin
                set_config(random_length(), 1'($urandom_range(1)));
                send_random_sequences(12);
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure;
        in_gap_pct    = 0;
        out_stall_pct = 0;
        set_config(16, MODE_FORWARD);
        hold_left = 300;
        repeat (20) send_sample(random_sample(), 1'b0);
        set_config(8, MODE_REVERSE);
        hold_left = 300;
        for (int i = 0; i < 24; i++) send_sample(random_sample(), i == 20);
    endtask

    // Receiver: drive ready and check each result transaction in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_sums.size() == 0) begin
                    $error("unexpected result: running_sum %0d chunk_position %0d",
                           o_running_sum, o_chunk_position);
                    mismatches++;
                end else begin
                    head_sum = pending_sums.pop_front();
                    if (o_running_sum !== head_sum.running_sum) begin
                        $error("running_sum: expected %0d, got %0d",
                               $signed(head_sum.running_sum), o_running_sum);
                        mismatches++;
                    end
                    if (o_chunk_position !== head_sum.chunk_pos) begin
                        $error("chunk_position: expected %0d, got %0d",
                               head_sum.chunk_pos, o_chunk_position);
                        mismatches++;
                    end
                    if (o_run_last !== head_sum.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               head_sum.run_last, o_run_last);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_sample        = '0;
        i_sequence_last = 1'b0;
        i_out_ready     = 1'b0;
        chunk_len_cfg   = 7'd64;
        reverse_cfg     = MODE_FORWARD;
        open_count      = '0;
        chunk_acc       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_forward_directed();
        test_reverse_directed();
        test_mid_chunk_changes();
        test_full_chunk_extremes();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/cps_pkg.sv
rtl/cps_regs.sv
rtl/cps_ctrl.sv
rtl/cps_dp.sv
rtl/chunked_prefix_sum.sv
bench/tb_chunked_prefix_sum.sv
